FILE: sv/tbci_pkg.sv
// Shared types, codes and decode functions for the tiny byte-code interpreter.
package tbci_pkg;

  localparam logic [7:0] OP_MOV  = 8'h05;
  localparam logic [7:0] OP_HLT  = 8'h08;
  localparam logic [7:0] OP_COPY = 8'h10;
  localparam logic [7:0] OP_INC  = 8'h0c;
  localparam logic [7:0] OP_DEC  = 8'h0d;
  localparam logic [7:0] OP_ADD  = 8'h0e;
  localparam logic [7:0] OP_SUB  = 8'h0f;

  localparam logic [7:0] REG_A0 = 8'h01;
  localparam logic [7:0] REG_D1 = 8'h04;
  localparam logic [7:0] REG_Y0 = 8'h0a;
  localparam logic [2:0] SLOT_Y0 = 3'd4;
  localparam int unsigned NUM_REGS = 5;

  localparam logic [7:0] VIDEO_LAST_REG = 8'he6;
  localparam logic [7:0] VIDEO_BASE     = 8'he7;
  localparam logic [7:0] SIGN_BIT_VALUE = 8'h80;

  localparam logic [1:0] ST_EXEC     = 2'd0;
  localparam logic [1:0] ST_HALT     = 2'd1;
  localparam logic [1:0] ST_BAD_REG  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic       reg_written;
    logic [2:0] reg_index;
    logic [7:0] reg_value;
    logic       video_written;
    logic [4:0] video_index;
    logic [7:0] video_value;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] held_op;
    logic [7:0] first_op;
  } ctl_t;

  function automatic logic op_known(input logic [7:0] op);
    logic k;
    case (op)
      OP_MOV, OP_COPY, OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_HLT: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] op_count(input logic [7:0] op);
    logic [1:0] n;
    case (op)
      OP_MOV, OP_COPY, OP_ADD, OP_SUB: n = 2'd2;
      OP_INC, OP_DEC: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic reg_valid(input logic [7:0] code);
    return ((code >= REG_A0) && (code <= REG_D1)) || (code == REG_Y0);
  endfunction

  function automatic logic [2:0] reg_slot(input logic [7:0] code);
    logic [7:0] d;
    d = code - REG_A0;
    return (code == REG_Y0) ? SLOT_Y0 : d[2:0];
  endfunction

endpackage

FILE: sv/tbci_exec.sv
// Instruction assembly and execution logic for one program byte.
module tbci_exec (
  input  logic [7:0]     byte_in,
  input  tbci_pkg::ctl_t ctl,
  input  logic [7:0]     rd_data,
  output logic [2:0]     rd_slot,
  output tbci_pkg::ctl_t ctl_nxt,
  output logic           res_vld,
  output logic           stop,
  output tbci_pkg::res_t res
);

  logic [7:0] ex_op;
  logic [7:0] ex_a;
  logic [7:0] ex_b;
  logic       d_ok;
  logic       s_ok;
  logic [2:0] d_slot;
  logic [7:0] vid_off;

  always_comb begin
    ctl_nxt = ctl;
    res_vld = 1'b0;
    ex_op = byte_in;
    ex_a = '0;
    ex_b = '0;
    case (ctl.phase)
      tbci_pkg::PH_FIRST: begin
        if (tbci_pkg::op_count(ctl.held_op) == 2'd1) begin
          ctl_nxt.phase = tbci_pkg::PH_OPCODE;
          ex_op = ctl.held_op;
          ex_a = byte_in;
          res_vld = 1'b1;
        end else begin
          ctl_nxt.first_op = byte_in;
          ctl_nxt.phase = tbci_pkg::PH_SECOND;
        end
      end
      tbci_pkg::PH_SECOND: begin
        ctl_nxt.phase = tbci_pkg::PH_OPCODE;
        ex_op = ctl.held_op;
        ex_a = ctl.first_op;
        ex_b = byte_in;
        res_vld = 1'b1;
      end
      default: begin
        ctl_nxt.phase = tbci_pkg::PH_OPCODE;
        if (tbci_pkg::op_known(byte_in)) begin
          if (tbci_pkg::op_count(byte_in) == 2'd0) begin
            res_vld = 1'b1;
          end else begin
            ctl_nxt.held_op = byte_in;
            ctl_nxt.phase = tbci_pkg::PH_FIRST;
          end
        end
      end
    endcase
  end

  assign d_ok = tbci_pkg::reg_valid(ex_a);
  assign s_ok = tbci_pkg::reg_valid(ex_b);
  assign d_slot = tbci_pkg::reg_slot(ex_a);
  assign rd_slot = (ex_op == tbci_pkg::OP_COPY) ? tbci_pkg::reg_slot(ex_b) : d_slot;
  assign vid_off = ex_a - tbci_pkg::VIDEO_BASE;

  always_comb begin
    res = '0;
    stop = 1'b0;
    if (ex_op == tbci_pkg::OP_HLT) begin
      res.status = tbci_pkg::ST_HALT;
      stop = 1'b1;
    end else if ((ex_op == tbci_pkg::OP_MOV) && (ex_a > tbci_pkg::VIDEO_LAST_REG)) begin
      res.video_written = 1'b1;
      res.video_index = vid_off[4:0];
      res.video_value = ex_b;
    end else if (!d_ok) begin
      res.status = tbci_pkg::ST_BAD_REG;
      stop = 1'b1;
    end else begin
      res.reg_written = 1'b1;
      res.reg_index = d_slot;
      case (ex_op)
        tbci_pkg::OP_MOV: res.reg_value = ex_b;
        tbci_pkg::OP_COPY: begin
          if (!s_ok) begin
            res = '0;
            res.status = tbci_pkg::ST_BAD_REG;
            stop = 1'b1;
          end else begin
            res.reg_value = rd_data;
          end
        end
        tbci_pkg::OP_INC: res.reg_value = rd_data + 8'd1;
        tbci_pkg::OP_DEC: res.reg_value = rd_data - 8'd1;
        tbci_pkg::OP_ADD: begin
          if ((rd_data >= tbci_pkg::SIGN_BIT_VALUE) || (ex_b >= tbci_pkg::SIGN_BIT_VALUE)) begin
            res = '0;
            res.status = tbci_pkg::ST_OVERFLOW;
            stop = 1'b1;
          end else begin
            res.reg_value = rd_data + ex_b;
          end
        end
        default: res.reg_value = rd_data - ex_b;
      endcase
    end
  end

endmodule

FILE: sv/tiny_byte_code_interpreter.sv
// Top level of the tiny byte-code interpreter.
//
// The in_ channel carries the program one byte per transfer. Each completed
// instruction produces one transfer on the out_ channel, carrying its status
// and the register or video write that it made. Operand bytes, unknown
// opcodes and every byte after a stop produce no output transfer.
// A byte is captured in an input register, then decoded and executed
// combinationally into the output register, from which its result is offered.
// The block takes one byte every cycle while the output is not stalled; a byte
// moves from the input register whenever the output register is empty or
// being drained, so a stalled receiver backs up through in_tready after one
// further byte is held. Halt, an invalid register code or an add overflow
// stops the block: bytes are still taken but dropped until reset.
// Reset (synchronous, active low) clears the registers, the instruction
// assembly state, the stop flag and both pipeline valid flags.
module tiny_byte_code_interpreter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] program_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [2] reg_written, [5:3] reg_index, [13:6] reg_value,
  // [14] video_written, [19:15] video_index, [27:20] video_value, [31:28] zero
  output logic [31:0] out_tdata
);

  logic            in_vld_r;
  logic [7:0]      in_byte_r;
  logic            out_vld_r;
  tbci_pkg::res_t  res_r;
  logic            stopped_r;
  tbci_pkg::ctl_t  ctl_r;
  logic [7:0]      regs_r [tbci_pkg::NUM_REGS];

  logic            adv;
  logic            fire;
  logic [2:0]      rd_slot;
  logic [7:0]      rd_data;
  tbci_pkg::ctl_t  ctl_nxt;
  logic            res_vld;
  logic            stop;
  tbci_pkg::res_t  res_nxt;

  assign adv = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign fire = in_vld_r && adv && !stopped_r;
  assign rd_data = (rd_slot < 3'(tbci_pkg::NUM_REGS)) ? regs_r[rd_slot] : '0;

  tbci_exec u_exec (
    .byte_in (in_byte_r),
    .ctl     (ctl_r),
    .rd_data (rd_data),
    .rd_slot (rd_slot),
    .ctl_nxt (ctl_nxt),
    .res_vld (res_vld),
    .stop    (stop),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      stopped_r <= 1'b0;
      ctl_r <= '0;
      for (int i = 0; i < tbci_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (adv) begin
        out_vld_r <= fire && res_vld;
      end
      if (fire) begin
        ctl_r <= ctl_nxt;
        if (res_vld) begin
          stopped_r <= stop;
          if (res_nxt.reg_written) begin
            regs_r[res_nxt.reg_index] <= res_nxt.reg_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {4'b0000, res_r.video_value, res_r.video_index, res_r.video_written,
                      res_r.reg_value, res_r.reg_index, res_r.reg_written, res_r.status};

  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stop flag cleared without reset");

  a_stop_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stopped_r) |-> (out_vld_r && (res_r.status != tbci_pkg::ST_EXEC)))
    else $error("block stopped without an error or halt result");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.reg_written && res_r.video_written))
    else $error("result reports both a register and a video write");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.status != tbci_pkg::ST_EXEC)) |->
      (!res_r.reg_written && !res_r.video_written))
    else $error("stopping result also reports a write");

  a_reg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.reg_written) |-> (res_r.reg_index < 3'(tbci_pkg::NUM_REGS)))
    else $error("register index out of range");

endmodule

FILE: bench/tbci_result_checker.sv
// Result checker for the tiny byte-code interpreter: predicts each instruction result and compares.
`timescale 1ns / 100ps
module tbci_result_checker
  import tbci_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          bad_results,
  output int          results_due,
  output logic [4:0]  reg_msb
);

  logic       halted;
  logic [1:0] phase;
  logic [7:0] held_op;
  logic [7:0] first_byte;
  logic [7:0] regs [NUM_REGS];
  res_t       due_results [$];

  function automatic int operand_bytes(input logic [7:0] op);
    case (op)
      OP_MOV, OP_COPY, OP_ADD, OP_SUB: return 2;
      OP_INC, OP_DEC: return 1;
      OP_HLT: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int slot_of(input logic [7:0] code);
    if (code >= REG_A0 && code <= REG_D1) begin
      return int'(code - REG_A0);
    end
    if (code == REG_Y0) begin
      return int'(SLOT_Y0);
    end
    return -1;
  endfunction

  task automatic execute_instruction(input logic [7:0] op, input logic [7:0] a,
                                     input logic [7:0] b);
    res_t       r;
    int         d;
    int         s;
    logic       wr;
    logic [7:0] nv;
    logic [7:0] vi;
    r = '0;
    wr = 1'b0;
    nv = 8'h00;
    d = slot_of(a);
    s = slot_of(b);
    if (op == OP_HLT) begin
      r.status = ST_HALT;
    end else if (op == OP_MOV && a > VIDEO_LAST_REG) begin
      vi = a - VIDEO_BASE;
      r.video_written = 1'b1;
      r.video_index = vi[4:0];
      r.video_value = b;
    end else if (d < 0 || (op == OP_COPY && s < 0)) begin
      r.status = ST_BAD_REG;
    end else begin
      case (op)
        OP_MOV: nv = b;
        OP_COPY: nv = regs[s];
        OP_INC: nv = regs[d] + 8'd1;
        OP_DEC: nv = regs[d] - 8'd1;
        OP_ADD: nv = regs[d] + b;
        default: nv = regs[d] - b;
      endcase
      if (op == OP_ADD && (regs[d] >= SIGN_BIT_VALUE || b >= SIGN_BIT_VALUE)) begin
        r.status = ST_OVERFLOW;
      end else begin
        wr = 1'b1;
      end
    end
    if (wr) begin
      regs[d] = nv;
      r.reg_written = 1'b1;
      r.reg_index = d[2:0];
      r.reg_value = nv;
    end
    if (r.status != ST_EXEC) begin
      halted = 1'b1;
    end
    due_results.push_back(r);
  endtask

  task automatic take_program_byte(input logic [7:0] pb);
    int n;
    if (!halted) begin
      case (phase)
        PH_FIRST: begin
          if (operand_bytes(held_op) == 1) begin
            phase = PH_OPCODE;
            execute_instruction(held_op, pb, 8'h00);
          end else begin
            first_byte = pb;
            phase = PH_SECOND;
          end
        end
        PH_SECOND: begin
          phase = PH_OPCODE;
          execute_instruction(held_op, first_byte, pb);
        end
        default: begin
          phase = PH_OPCODE;
          n = operand_bytes(pb);
          if (n == 0) begin
            execute_instruction(pb, 8'h00, 8'h00);
          end else if (n > 0) begin
            held_op = pb;
            phase = PH_FIRST;
          end
        end
      endcase
    end
  endtask

  task automatic check_result(input logic [31:0] d);
    res_t got;
    res_t want;
    got = {d[1:0], d[2], d[5:3], d[13:6], d[14], d[19:15], d[27:20]};
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none, actual %h", $time, d);
      bad_results = bad_results + 1;
    end else begin
      want = due_results.pop_front();
      if (got !== want || d[31:28] !== 4'h0) begin
        $display("%0t: result mismatch, expected status %0d reg %0b/%0d/%h video %0b/%0d/%h pad 0",
                 $time, want.status, want.reg_written, want.reg_index, want.reg_value,
                 want.video_written, want.video_index, want.video_value);
        $display("%0t:                  actual status %0d reg %0b/%0d/%h video %0b/%0d/%h pad %h",
                 $time, got.status, got.reg_written, got.reg_index, got.reg_value,
                 got.video_written, got.video_index, got.video_value, d[31:28]);
        bad_results = bad_results + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      halted = 1'b0;
      phase = PH_OPCODE;
      held_op = 8'h00;
      first_byte = 8'h00;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] = 8'h00;
      end
      due_results.delete();
      bad_results = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        take_program_byte(in_tdata);
      end
    end
    results_due <= due_results.size();
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_msb[i] <= regs[i][7];
    end
  end

endmodule

FILE: bench/tiny_byte_code_interpreter_test.sv
// Testbench top for the tiny byte-code interpreter: drives program bytes and gives the verdict.
`timescale 1ns / 100ps
module tiny_byte_code_interpreter_test;
  import tbci_pkg::*;

  localparam int RANDOM_BYTES = 900;
  localparam int PACE_STEP = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] CODE_B1 = REG_A0 + 8'd1;
  localparam logic [7:0] CODE_C0 = REG_A0 + 8'd2;
  localparam logic [7:0] VIDEO_TOP = 8'hff;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  int          bad_results;
  int          results_due;
  logic [4:0]  reg_msb;
  int          send_idle_pct = 38;
  int          recv_idle_pct = 80;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  opening_bytes [$];

  always #5 clk = ~clk;

  tiny_byte_code_interpreter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tbci_result_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .bad_results (bad_results),
    .results_due (results_due),
    .reg_msb     (reg_msb)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tiny_byte_code_interpreter_test: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] good_reg();
    int k;
    k = $urandom_range(0, 4);
    return (k == 4) ? REG_Y0 : REG_A0 + k[7:0];
  endfunction

  function automatic logic [7:0] bad_reg();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      return VIDEO_LAST_REG;
    end
    do c = 8'($urandom_range(0, VIDEO_LAST_REG)); while (reg_valid(c));
    return c;
  endfunction

  function automatic logic [7:0] free_reg();
    logic [7:0] c;
    do c = good_reg(); while (reg_msb[reg_slot(c)]);
    return c;
  endfunction

  function automatic logic [7:0] junk_op();
    logic [7:0] c;
    do c = 8'($urandom); while (op_known(c));
    return c;
  endfunction

  function automatic logic [7:0] any_value();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hff;
      2: v = 8'h80;
      3: v = 8'h7f;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic random_instruction();
    int         pick;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_byte(junk_op());
    end else if (pick < 25) begin
      send_byte(OP_MOV);
      send_byte(good_reg());
      send_byte(any_value());
    end else if (pick < 35) begin
      v = 8'($urandom_range(VIDEO_BASE, VIDEO_TOP));
      send_byte(OP_MOV);
      send_byte(v);
      send_byte(any_value());
    end else if (pick < 48) begin
      send_byte(OP_COPY);
      send_byte(good_reg());
      send_byte(good_reg());
    end else if (pick < 58) begin
      send_byte(OP_INC);
      send_byte(good_reg());
    end else if (pick < 68) begin
      send_byte(OP_DEC);
      send_byte(good_reg());
    end else if (pick < 85 && $countones(~reg_msb) >= 2) begin
      // Only the instruction just finished is missing from reg_msb, so a free
      // register is still known once the opcode has gone.
      send_byte(OP_ADD);
      send_byte(free_reg());
      v = ($urandom_range(0, 3) == 0) ? 8'h7f : 8'($urandom_range(0, 8'h7f));
      send_byte(v);
    end else begin
      send_byte(OP_SUB);
      send_byte(good_reg());
      send_byte(any_value());
    end
  endtask

  task automatic stop_block();
    logic [7:0] r;
    logic [7:0] v;
    r = good_reg();
    case ($urandom_range(0, 7))
      0: send_byte(OP_HLT);
      1: begin
        send_byte(OP_MOV);
        send_byte(bad_reg());
        send_byte(any_value());
      end
      2: begin
        send_byte($urandom_range(0, 1) ? OP_INC : OP_DEC);
        send_byte(bad_reg());
      end
      3: begin
        send_byte(OP_COPY);
        send_byte(bad_reg());
        send_byte(r);
      end
      4: begin
        send_byte(OP_COPY);
        send_byte(r);
        send_byte(bad_reg());
      end
      5: begin
        send_byte($urandom_range(0, 1) ? OP_ADD : OP_SUB);
        send_byte(bad_reg());
        send_byte(any_value());
      end
      6: begin
        v = 8'($urandom_range(SIGN_BIT_VALUE, 8'hff));
        send_byte(OP_ADD);
        send_byte(r);
        send_byte(v);
      end
      default: begin
        v = 8'($urandom);
        send_byte(OP_MOV);
        send_byte(r);
        send_byte(v | SIGN_BIT_VALUE);
        v = 8'($urandom_range(0, 8'h7f));
        send_byte(OP_ADD);
        send_byte(r);
        send_byte(v);
      end
    endcase
  endtask

  initial begin
    opening_bytes = '{OP_MOV, REG_A0, 8'hff, OP_MOV, VIDEO_TOP, 8'ha5,
                      OP_MOV, VIDEO_BASE, 8'h00, OP_COPY, REG_Y0, REG_A0,
                      OP_INC, REG_A0, OP_DEC, CODE_B1, OP_SUB, CODE_C0, 8'h01,
                      OP_ADD, REG_D1, 8'h7f, 8'hff, OP_COPY, REG_A0, REG_Y0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (opening_bytes[i]) begin
      send_byte(opening_bytes[i]);
    end
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= 2 * PACE_STEP) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (bytes_sent >= PACE_STEP) begin
        send_idle_pct = 80;
        recv_idle_pct = 38;
      end
      random_instruction();
    end
    // Once stopped, the block takes every further transfer and drops it.
    stop_block();
    repeat (4) random_instruction();
    repeat ($urandom_range(4, 12)) send_byte(8'($urandom));
    in_tvalid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("tiny_byte_code_interpreter_test: done, clean");
    end else begin
      $display("tiny_byte_code_interpreter_test: done, errors");
    end
    $finish;
  end

endmodule
